/* src/cdc_pkg.sv */
`default_nettype none
package cdc_pkg;

  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DIST_W  = 21;
  localparam int JDN_W   = 23;
  localparam int CFG_AW  = 1;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [JDN_W-1:0]   jdn_t;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_NEXT = 2'd1,
    ACT_PREV = 2'd2,
    ACT_DIST = 2'd3
  } action_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_EARLIEST = 1'd0,
    REG_LATEST   = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    year_t  year;
    month_t month;
    day_t   day;
  } date_t;

  typedef struct packed {
    action_t action;
    date_t   date;
  } cdc_req_t;

  typedef struct packed {
    year_t earliest;
    year_t latest;
  } cdc_cfg_t;

  // Quotient by 100 through a reciprocal; exact for x below 12800
  function automatic logic [6:0] div100(input logic [13:0] x);
    logic [25:0] p;
    p = 26'(x) * 26'd5243;
    return p[25:19];
  endfunction

  // Gregorian rule: by 4, and not by 100 unless by 400
  function automatic logic is_leap(input year_t y);
    logic [6:0]  q;
    logic [11:0] r;
    q = div100(14'(y));
    r = 12'(y) - 12'(q) * 12'd100;
    return (y[1:0] == 2'd0) && ((r != 12'd0) || (q[1:0] == 2'd0));
  endfunction

  // Month length in a common year
  function automatic day_t month_len(input month_t m);
    day_t d;
    unique case (m)
      4'd2:                      d = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  function automatic day_t days_in(input year_t y, input month_t m);
    return ((m == 4'd2) && is_leap(y)) ? 5'd29 : month_len(m);
  endfunction

  // Force each field of a raw date into its accepted range
  function automatic date_t validate(input date_t raw, input cdc_cfg_t cfg);
    date_t o;
    o.year  = ((raw.year < cfg.earliest) || (raw.year > cfg.latest)) ? cfg.earliest : raw.year;
    o.month = ((raw.month == 4'd0) || (raw.month > 4'd12)) ? 4'd1 : raw.month;
    if ((o.month == 4'd2) && is_leap(o.year) && (raw.day == 5'd29)) begin
      o.day = 5'd29;
    end else if ((o.month == 4'd2) && (raw.day > 5'd28)) begin
      o.day = 5'd28;
    end else if ((raw.day == 5'd0) || (raw.day > month_len(o.month))) begin
      o.day = 5'd1;
    end else begin
      o.day = raw.day;
    end
    return o;
  endfunction

  // Month term of the day number, 367*(m-2+12a)/12
  function automatic logic [8:0] month_term(input month_t m);
    logic [8:0] t;
    unique case (m)
      4'd1:    t = 9'd336;
      4'd2:    t = 9'd367;
      4'd3:    t = 9'd30;
      4'd4:    t = 9'd61;
      4'd5:    t = 9'd91;
      4'd6:    t = 9'd122;
      4'd7:    t = 9'd152;
      4'd8:    t = 9'd183;
      4'd9:    t = 9'd214;
      4'd10:   t = 9'd244;
      4'd11:   t = 9'd275;
      default: t = 9'd305;
    endcase
    return t;
  endfunction

  // Julian day number of a valid date; every term stays positive
  function automatic jdn_t jdn(input date_t dt);
    logic        a;
    logic [13:0] ya;
    logic [13:0] yc;
    logic [23:0] t1;
    logic [6:0]  q;
    logic [8:0]  t3;
    a  = (dt.month <= 4'd2);
    ya = 14'(dt.year) + 14'd4800 - 14'(a);
    yc = 14'(dt.year) + 14'd4900 - 14'(a);
    t1 = 24'(ya) * 24'd1461;
    q  = div100(yc);
    t3 = 9'(9'(q) * 9'd3);
    return JDN_W'(t1[23:2]) + JDN_W'(month_term(dt.month)) - JDN_W'(t3[8:2])
           + JDN_W'(dt.day) - JDN_W'(32075);
  endfunction

endpackage
`default_nettype wire

/* src/cdc_in_stage.sv */
`default_nettype none
module cdc_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire cdc_pkg::cdc_req_t req_data,
  output logic                   hold_valid,
  input  wire logic              hold_take,
  output cdc_pkg::cdc_req_t      hold_data
);
  import cdc_pkg::*;

  logic     valid_r;
  cdc_req_t data_r;

  // Free when empty or when the held request moves on this cycle
  assign req_ready  = !valid_r || hold_take;
  assign hold_valid = valid_r;
  assign hold_data  = data_r;

  // Hold one request for the execute stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (req_ready) begin
      valid_r <= req_valid;
    end
    if (req_ready && req_valid) begin
      data_r <= req_data;
    end
  end

endmodule
`default_nettype wire

/* src/cdc_date_exec.sv */
`default_nettype none
module cdc_date_exec (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cdc_pkg::cdc_cfg_t cfg,
  input  wire logic              req_valid,
  output logic                   req_take,
  input  wire cdc_pkg::cdc_req_t req_data,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output cdc_pkg::date_t         res_date,
  output cdc_pkg::dist_t         res_dist
);
  import cdc_pkg::*;

  date_t cur_r, cur_nxt;
  date_t out_date_r;
  dist_t out_dist_r, dist_nxt;
  logic  out_valid_r;

  date_t op_date;
  jdn_t  jdn_cur, jdn_op, jdn_diff;
  day_t  dim_cur;
  month_t prev_month;

  assign req_take  = req_valid && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res_date  = out_date_r;
  assign res_dist  = out_dist_r;

  // Operand checks and day-number distance
  assign op_date    = validate(req_data.date, cfg);
  assign jdn_cur    = jdn(cur_r);
  assign jdn_op     = jdn(op_date);
  assign jdn_diff   = (jdn_cur >= jdn_op) ? (jdn_cur - jdn_op) : (jdn_op - jdn_cur);
  assign dim_cur    = days_in(cur_r.year, cur_r.month);
  assign prev_month = cur_r.month - 4'd1;

  // Next stored date and distance for the current request
  always_comb begin
    cur_nxt  = cur_r;
    dist_nxt = '0;
    unique case (req_data.action)
      ACT_LOAD: begin
        cur_nxt = op_date;
      end
      ACT_NEXT: begin
        if (cur_r.day < dim_cur) begin
          cur_nxt.day = cur_r.day + 5'd1;
        end else if (cur_r.month < 4'd12) begin
          cur_nxt.month = cur_r.month + 4'd1;
          cur_nxt.day   = 5'd1;
        end else begin
          cur_nxt.year  = cur_r.year + 12'd1;
          cur_nxt.month = 4'd1;
          cur_nxt.day   = 5'd1;
        end
      end
      ACT_PREV: begin
        if (cur_r.day > 5'd1) begin
          cur_nxt.day = cur_r.day - 5'd1;
        end else if (cur_r.month <= 4'd1) begin
          cur_nxt.year  = cur_r.year - 12'd1;
          cur_nxt.month = 4'd12;
          cur_nxt.day   = 5'd31;
        end else begin
          cur_nxt.month = prev_month;
          cur_nxt.day   = days_in(cur_r.year, prev_month);
        end
      end
      ACT_DIST: begin
        dist_nxt = (jdn_diff[JDN_W-1:DIST_W] != '0) ? DIST_MAX : jdn_diff[DIST_W-1:0];
      end
      default: begin
        cur_nxt = cur_r;
      end
    endcase
  end

  // Advance stored date and result register together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '{year: 12'd1900, month: 4'd1, day: 5'd1};
      out_valid_r <= 1'b0;
    end else begin
      if (req_take) begin
        cur_r <= cur_nxt;
      end
      if (req_take) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (req_take) begin
      out_date_r <= cur_nxt;
      out_dist_r <= dist_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/calendar_date_counter_unit.sv */
`default_nettype none
// Channel  Ports                         Moves
// in       in_tvalid/in_tready/in_tdata  command (tuser) and raw date
// out      out_tvalid/out_tready/...     stored date and day distance
// cfg      cfg_we/cfg_index/cfg_wdata    year range registers
//
// One request per cycle sustained while out_tready holds; a request's result
// is offered once it has passed the input register and then the date logic
// into the result register. The stored date updates as the request enters
// the result register, so the next request sees it at once. Reset sets the
// date to 1900-01-01 and the year range to 1900..2022. A stalled result holds
// the result register while the input register still takes one more request.
module calendar_date_counter_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // [11:0] in_year, [15:12] in_month, [20:16] in_day, [23:21] zero
  input  wire logic [23:0]                in_tdata,
  // [1:0] action
  input  wire logic [1:0]                 in_tuser,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // [11:0] out_year, [15:12] out_month, [20:16] out_day,
  // [41:21] day_distance, [47:42] zero
  output logic [47:0]                     out_tdata,
  input  wire logic                       cfg_we,
  input  wire logic [cdc_pkg::CFG_AW-1:0] cfg_index,
  input  wire logic [cdc_pkg::YEAR_W-1:0] cfg_wdata
);
  import cdc_pkg::*;

  year_t     earliest_r, latest_r;
  cdc_cfg_t  cfg;
  cdc_req_t  in_req, hold_req;
  logic      hold_valid, hold_take;
  date_t     res_date;
  dist_t     res_dist;

  // Write the year range registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      earliest_r <= 12'd1900;
      latest_r   <= 12'd2022;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_EARLIEST: earliest_r <= cfg_wdata;
        REG_LATEST:   latest_r   <= cfg_wdata;
        default:      earliest_r <= earliest_r;
      endcase
    end
  end

  assign cfg.earliest = earliest_r;
  assign cfg.latest   = latest_r;

  // Unpack the request
  assign in_req.action     = action_t'(in_tuser);
  assign in_req.date.year  = in_tdata[11:0];
  assign in_req.date.month = in_tdata[15:12];
  assign in_req.date.day   = in_tdata[20:16];

  cdc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_data   (in_req),
    .hold_valid (hold_valid),
    .hold_take  (hold_take),
    .hold_data  (hold_req)
  );

  cdc_date_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .req_valid (hold_valid),
    .req_take  (hold_take),
    .req_data  (hold_req),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_date  (res_date),
    .res_dist  (res_dist)
  );

  // Pack the result
  assign out_tdata = {6'd0, res_dist, res_date.day, res_date.month, res_date.year};

endmodule
`default_nettype wire
